### hw/rtl/kcd_pkg.sv
// Shared constants and types for the key click detector.
`timescale 1ns / 1ps
`default_nettype none
package kcd_pkg;

   localparam int NUM_KEYS      = 4;
   localparam int COUNTER_WIDTH = 16;

   localparam int KEY_SLOTS     = 4;
   localparam int THRESH_W      = 16;
   localparam int MASK_W        = 4;
   localparam int MODE_TABLE_W  = 8;
   localparam int KEYS_IN_USE_W = 3;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int CMP_W = (COUNTER_WIDTH > THRESH_W) ? COUNTER_WIDTH : THRESH_W;

   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_SINGLE = 2'd1;
   localparam logic [1:0] MODE_DOUBLE = 2'd2;
   localparam logic [1:0] MODE_LONG   = 2'd3;

   localparam logic [1:0] DONE_IDLE  = 2'd0;
   localparam logic [1:0] DONE_ARMED = 2'd1;
   localparam logic [1:0] DONE_FIRED = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD_KEY0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD_KEY1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD_KEY2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD_KEY3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_HIGH    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE_TABLE     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_KEYS_IN_USE    = 3'd6;

   typedef struct packed {
      logic [KEY_SLOTS-1:0][THRESH_W-1:0] threshold;
      logic [MASK_W-1:0]                  active_high;
      logic [MODE_TABLE_W-1:0]            mode_table;
      logic [KEYS_IN_USE_W-1:0]           keys_in_use;
   } cfg_type;

   typedef struct packed {
      logic       step;
      logic       enable;
      logic       pressed;
      logic [1:0] mode;
   } key_ctl_type;

endpackage
`default_nettype wire

### hw/rtl/kcd_csr.sv
// Configuration register file of the key click detector.
`timescale 1ns / 1ps
`default_nettype none
module kcd_csr
   import kcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [CSR_INDEX_W-1:0] wr_index,
   input  wire logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_THRESHOLD_KEY0: cfg_in.threshold[0] = wr_data[THRESH_W-1:0];
            REG_THRESHOLD_KEY1: cfg_in.threshold[1] = wr_data[THRESH_W-1:0];
            REG_THRESHOLD_KEY2: cfg_in.threshold[2] = wr_data[THRESH_W-1:0];
            REG_THRESHOLD_KEY3: cfg_in.threshold[3] = wr_data[THRESH_W-1:0];
            REG_ACTIVE_HIGH:    cfg_in.active_high  = wr_data[MASK_W-1:0];
            REG_MODE_TABLE:     cfg_in.mode_table   = wr_data[MODE_TABLE_W-1:0];
            REG_KEYS_IN_USE:    cfg_in.keys_in_use  = wr_data[KEYS_IN_USE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### hw/rtl/kcd_key.sv
// Per-key counter and done state with click / long-press event logic.
`timescale 1ns / 1ps
`default_nettype none
module kcd_key
   import kcd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  key_ctl_type              ctl,
   input  wire logic [THRESH_W-1:0] threshold,
   output logic                     fire
);

   logic [COUNTER_WIDTH-1:0] cnt_ff, cnt_in, cnt_inc, cnt_rel;
   logic [1:0]               done_ff, done_in;
   logic [CMP_W-1:0]         thr_ext, cnt_ext, inc_ext, rel_ext;
   logic                     reach;

   assign thr_ext = CMP_W'(threshold);
   assign cnt_ext = CMP_W'(cnt_ff);
   assign cnt_inc = (cnt_ext < thr_ext && cnt_ff != '1) ? cnt_ff + 1'b1 : cnt_ff;
   assign inc_ext = CMP_W'(cnt_inc);
   assign reach   = inc_ext >= thr_ext;
   // released double-click: count only once the first press is seen
   assign cnt_rel = (done_ff != DONE_IDLE) ? cnt_inc : cnt_ff;
   assign rel_ext = CMP_W'(cnt_rel);

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = done_ff;
      fire    = 1'b0;
      if (ctl.enable) begin
         if (ctl.pressed) begin
            cnt_in = cnt_inc;
            case (ctl.mode)
               MODE_SINGLE: begin
                  if (reach && done_ff == DONE_IDLE) begin
                     fire    = 1'b1;
                     done_in = DONE_ARMED;
                  end
               end
               MODE_LONG: begin
                  fire = reach;
               end
               MODE_DOUBLE: begin
                  if (reach && done_ff == DONE_ARMED) begin
                     fire    = 1'b1;
                     done_in = DONE_FIRED;
                  end
               end
               default: ;
            endcase
         end else if (ctl.mode == MODE_DOUBLE) begin
            cnt_in = cnt_rel;
            if (cnt_rel != '0 && rel_ext <= thr_ext && done_ff == DONE_IDLE) begin
               done_in = DONE_ARMED;
            end else if (rel_ext >= thr_ext) begin
               cnt_in  = '0;
               done_in = DONE_IDLE;
            end
         end else begin
            cnt_in  = '0;
            done_in = DONE_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= DONE_IDLE;
      end else if (ctl.step) begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/key_click_detector_unit.sv
// Top level of the key click detector: config registers, key cells, result register.
//
// Usage:
//  - req channel: one transaction per scan tick, req_key_levels bit i is key i's level.
//  - rsp channel: one transaction per tick, rsp_fire_mask bit i set when key i fired.
//  - csr channel: write register csr_index with csr_data; always ready, takes
//    effect on the next cycle. Indexes beyond keys_in_use's (6) are ignored.
//  - Result: the result of a tick is on rsp in the cycle after its transaction.
//  - Throughput: one tick per cycle while rsp is not stalled; every key cell
//    updates its counter and done state in the same cycle the tick is taken.
//  - The single result register decouples the sides: req_ready is high
//    whenever the register is empty or is being emptied in the same cycle.
//  - Receiver stall: the result holds and req_ready drops until it is taken.
//  - Reset (synchronous): config registers, counters and done states clear,
//    and no result is pending.
//
`timescale 1ns / 1ps
`default_nettype none
module key_click_detector_unit
   import kcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [MASK_W-1:0]      req_key_levels,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [MASK_W-1:0]           rsp_fire_mask,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type            cfg;
   logic               req_take;
   logic [MASK_W-1:0]  fire;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;

   assign csr_ready = 1'b1;

   kcd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   for (genvar k = 0; k < MASK_W; k++) begin : g_key
      if (k < NUM_KEYS) begin : g_used
         key_ctl_type ctl;
         assign ctl.step    = req_take;
         assign ctl.mode    = cfg.mode_table[2*k +: 2];
         assign ctl.enable  = (KEYS_IN_USE_W'(k) < cfg.keys_in_use) &&
                              (ctl.mode != MODE_NONE);
         assign ctl.pressed = req_key_levels[k] == cfg.active_high[k];
         kcd_key u_key (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .threshold (cfg.threshold[k]),
            .fire      (fire[k])
         );
      end else begin : g_unused
         assign fire[k] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_mask_in  = rsp_mask_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_mask_in  = fire;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_mask_ff <= rsp_mask_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fire_mask = rsp_mask_ff;

   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted tick produced no result");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result is stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule
`default_nettype wire
